// ===== hdl/visited_bloom_filter_macros.svh =====
// ----------------------------------------------------------------------------
// visited bloom filter assertion macros
// concurrent assertion helpers, compiled out when NO_ASSERTIONS is set
// ----------------------------------------------------------------------------
`ifndef VISITED_BLOOM_FILTER_MACROS_SVH
`define VISITED_BLOOM_FILTER_MACROS_SVH

`ifndef NO_ASSERTIONS
`define BVF_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define BVF_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define BVF_ASSERT(lbl, clk, rst, prop, msg)
`define BVF_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

// ===== hdl/bvf_pkg.sv =====
// ----------------------------------------------------------------------------
// bvf_pkg
// shared constants, hash step table and control types of the bloom filter
// ----------------------------------------------------------------------------
`default_nettype none

package bvf_pkg;

   localparam int FILTER_BITS = 2048;
   localparam int ADDR_W      = $clog2(FILTER_BITS);
   localparam int PROBE_COUNT = 3;
   localparam int PROBE_W     = (PROBE_COUNT > 1) ? $clog2(PROBE_COUNT) : 1;
   localparam int KEY_BYTES   = 32;
   localparam int KEY_LEN     = (KEY_BYTES < 17) ? 17 : ((KEY_BYTES > 32) ? 32 : KEY_BYTES);
   localparam int TAIL_SHIFT  = (KEY_LEN - 16) * 8;
   localparam int COUNT_W     = 16;

   localparam logic [63:0] SEED_FIRST  = 64'h0000_0000_4F46_4653;
   localparam logic [63:0] SEED_SECOND = 64'h4653_4E4F_5544_4E53;
   localparam logic [63:0] PRIME_ONE   = 64'h9E37_79B1_85EB_CA87;
   localparam logic [63:0] AVAL_MUL    = 64'h1656_6791_9E37_79F9;
   localparam logic [127:0] ACC_INIT_FULL = 128'(KEY_LEN) * {64'd0, PRIME_ONE};
   localparam logic [63:0] ACC_INIT    = ACC_INIT_FULL[63:0];

   localparam logic [63:0] SECRET [4] = '{
      64'hbe4ba423396cfeb8, 64'h1cad21f72c81017c,
      64'hdb979083e96dd4de, 64'h1f67b3b7a4a44072
   };

   localparam int HASH_STEPS = 19;
   localparam int STEP_W     = 5;

   typedef enum logic [3:0] {
      OP_NONE, OP_INIT, OP_MLL, OP_MHL, OP_MLH, OP_MHH,
      OP_CROSS, OP_FOLD, OP_LOAD2, OP_AVAL, OP_FINISH
   } hash_op_type;

   typedef enum logic [2:0] {
      ST_CLEAR, ST_IDLE, ST_HASH, ST_PROBE, ST_DRAIN, ST_DONE
   } state_type;

   typedef struct packed {
      logic        clear_en;
      logic        key_load;
      hash_op_type op;
      logic        seed_sel;
      logic        probe_en;
      logic        probe_first;
      logic        item_end;
      logic        rsp_load;
   } cmd_type;

   typedef struct packed {
      logic clear_last;
      logic rsp_free;
   } status_type;

   // one seeded hash: two folded 64x64 products, then the avalanche multiply
   function automatic hash_op_type step_op(input logic [STEP_W-1:0] step);
      hash_op_type op;
      case (step)
         5'd0:    op = OP_INIT;
         5'd1:    op = OP_MLL;
         5'd2:    op = OP_MHL;
         5'd3:    op = OP_MLH;
         5'd4:    op = OP_MHH;
         5'd5:    op = OP_CROSS;
         5'd6:    op = OP_FOLD;
         5'd7:    op = OP_LOAD2;
         5'd8:    op = OP_MLL;
         5'd9:    op = OP_MHL;
         5'd10:   op = OP_MLH;
         5'd11:   op = OP_MHH;
         5'd12:   op = OP_CROSS;
         5'd13:   op = OP_FOLD;
         5'd14:   op = OP_AVAL;
         5'd15:   op = OP_MLL;
         5'd16:   op = OP_MHL;
         5'd17:   op = OP_MLH;
         5'd18:   op = OP_FINISH;
         default: op = OP_NONE;
      endcase
      return op;
   endfunction

endpackage

`default_nettype wire

// ===== hdl/bvf_if.sv =====
// ----------------------------------------------------------------------------
// bvf channel interfaces
// request and response channels with valid / ready handshake
// ----------------------------------------------------------------------------
`default_nettype none

interface bvf_req_if;
   logic        valid;
   logic        ready;
   logic        operation;
   logic [63:0] key_word_0;
   logic [63:0] key_word_1;
   logic [63:0] key_word_2;
   logic [63:0] key_word_3;

   modport source (output valid, operation, key_word_0, key_word_1, key_word_2,
                   key_word_3, input ready);
   modport sink   (input valid, operation, key_word_0, key_word_1, key_word_2,
                   key_word_3, output ready);
endinterface

interface bvf_rsp_if;
   logic        valid;
   logic        ready;
   logic        is_visited;
   logic [15:0] entries_added;

   modport source (output valid, is_visited, entries_added, input ready);
   modport sink   (input valid, is_visited, entries_added, output ready);
endinterface

`default_nettype wire

// ===== hdl/bvf_ram.sv =====
// ----------------------------------------------------------------------------
// bvf_ram
// generic simple dual port ram, one write and one registered read port
// ----------------------------------------------------------------------------
`default_nettype none

module bvf_ram #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 2048
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata_ff
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

endmodule

`default_nettype wire

// ===== hdl/bvf_ctrl.sv =====
// ----------------------------------------------------------------------------
// bvf_ctrl
// sequencer: clearing pass, hash steps, probe accesses and response hand-off
// ----------------------------------------------------------------------------
`default_nettype none

module bvf_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  bvf_pkg::status_type status,
   output bvf_pkg::cmd_type    cmd
);

   bvf_pkg::state_type          state_ff, state_in;
   logic [bvf_pkg::STEP_W-1:0]  step_ff, step_in;
   logic                        seed_ff, seed_in;
   logic [bvf_pkg::PROBE_W-1:0] probe_ff, probe_in;
   logic                        step_last;
   logic                        probe_last;

   assign step_last  = (step_ff == bvf_pkg::STEP_W'(bvf_pkg::HASH_STEPS - 1));
   assign probe_last = (probe_ff == bvf_pkg::PROBE_W'(bvf_pkg::PROBE_COUNT - 1));

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         bvf_pkg::ST_CLEAR: if (status.clear_last) state_in = bvf_pkg::ST_IDLE;
         bvf_pkg::ST_IDLE:  if (req_valid) state_in = bvf_pkg::ST_HASH;
         bvf_pkg::ST_HASH:  if (step_last && seed_ff) state_in = bvf_pkg::ST_PROBE;
         bvf_pkg::ST_PROBE: if (probe_last) state_in = bvf_pkg::ST_DRAIN;
         bvf_pkg::ST_DRAIN: state_in = bvf_pkg::ST_DONE;
         bvf_pkg::ST_DONE:  if (status.rsp_free) state_in = bvf_pkg::ST_IDLE;
         default:           state_in = bvf_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      step_in  = step_ff;
      seed_in  = seed_ff;
      probe_in = probe_ff;
      case (state_ff)
         bvf_pkg::ST_IDLE: begin
            step_in  = '0;
            seed_in  = 1'b0;
            probe_in = '0;
         end
         bvf_pkg::ST_HASH: begin
            if (step_last) begin
               step_in = '0;
               seed_in = ~seed_ff;
            end else begin
               step_in = step_ff + 1'b1;
            end
         end
         bvf_pkg::ST_PROBE: probe_in = probe_ff + 1'b1;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= bvf_pkg::ST_CLEAR;
         step_ff  <= '0;
         seed_ff  <= 1'b0;
         probe_ff <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
         seed_ff  <= seed_in;
         probe_ff <= probe_in;
      end
   end

   always_comb begin
      req_ready       = (state_ff == bvf_pkg::ST_IDLE);
      cmd.clear_en    = (state_ff == bvf_pkg::ST_CLEAR);
      cmd.key_load    = req_ready && req_valid;
      cmd.op          = (state_ff == bvf_pkg::ST_HASH) ? bvf_pkg::step_op(step_ff)
                                                       : bvf_pkg::OP_NONE;
      cmd.seed_sel    = seed_ff;
      cmd.probe_en    = (state_ff == bvf_pkg::ST_PROBE);
      cmd.probe_first = (state_ff == bvf_pkg::ST_PROBE) && (probe_ff == '0);
      cmd.item_end    = (state_ff == bvf_pkg::ST_DRAIN);
      cmd.rsp_load    = (state_ff == bvf_pkg::ST_DONE) && status.rsp_free;
   end

endmodule

`default_nettype wire

// ===== hdl/bvf_datapath.sv =====
// ----------------------------------------------------------------------------
// bvf_datapath
// shared 32x32 multiplier hash engine, probe address walk, filter ram,
// saturating add counter and response register
// ----------------------------------------------------------------------------
`default_nettype none
`include "visited_bloom_filter_macros.svh"

module bvf_datapath (
   input  logic                         clock,
   input  logic                         reset,
   input  bvf_pkg::cmd_type             cmd,
   output bvf_pkg::status_type          status,
   input  logic                         operation,
   input  logic [63:0]                  key_word_0,
   input  logic [63:0]                  key_word_1,
   input  logic [63:0]                  key_word_2,
   input  logic [63:0]                  key_word_3,
   input  logic                         rsp_ready,
   output logic                         rsp_valid,
   output logic                         rsp_is_visited,
   output logic [bvf_pkg::COUNT_W-1:0]  rsp_entries_added
);

   localparam int AW = bvf_pkg::ADDR_W;

   logic [255:0] key_ff;
   logic         adding_ff;
   logic [63:0]  a_ff, a_in, b_ff, b_in, acc_ff, acc_in;
   logic [63:0]  ll_ff, ll_in, hl_ff, hl_in, lh_ff, lh_in, hh_ff, hh_in;
   logic [63:0]  cross_ff, cross_in, ha_ff, ha_in, hb_ff, hb_in;
   logic [63:0]  seed, tail_lo, tail_hi, upper, lower, aval, fin_lo, fin_mid;
   logic [255:0] tail;
   logic [31:0]  mul_x, mul_y;
   logic [63:0]  mul_p;
   logic [AW-1:0] clr_addr_ff, pos_ff, pos_in, probe_addr;
   logic         all_set_ff, rd_pend_ff;
   logic [bvf_pkg::COUNT_W-1:0] count_ff;
   logic         rsp_valid_ff, rsp_visited_ff;
   logic [bvf_pkg::COUNT_W-1:0] rsp_count_ff;
   logic         mem_we, mem_wdata, mem_rdata;
   logic [AW-1:0] mem_waddr;

   assign seed    = cmd.seed_sel ? bvf_pkg::SEED_SECOND : bvf_pkg::SEED_FIRST;
   assign tail    = key_ff >> bvf_pkg::TAIL_SHIFT;
   assign tail_lo = tail[63:0];
   assign tail_hi = tail[127:64];

   always_comb begin
      case (cmd.op)
         bvf_pkg::OP_MHL: begin mul_x = a_ff[63:32]; mul_y = b_ff[31:0];  end
         bvf_pkg::OP_MLH: begin mul_x = a_ff[31:0];  mul_y = b_ff[63:32]; end
         bvf_pkg::OP_MHH: begin mul_x = a_ff[63:32]; mul_y = b_ff[63:32]; end
         default:         begin mul_x = a_ff[31:0];  mul_y = b_ff[31:0];  end
      endcase
   end

   assign mul_p   = {32'd0, mul_x} * {32'd0, mul_y};
   assign upper   = {32'd0, hl_ff[63:32]} + {32'd0, cross_ff[63:32]} + hh_ff;
   assign lower   = {cross_ff[31:0], ll_ff[31:0]};
   assign aval    = acc_ff ^ (acc_ff >> 37);
   assign fin_mid = hl_ff + lh_ff;
   assign fin_lo  = ll_ff + {fin_mid[31:0], 32'd0};

   always_comb begin
      a_in = a_ff; b_in = b_ff; acc_in = acc_ff;
      ll_in = ll_ff; hl_in = hl_ff; lh_in = lh_ff; hh_in = hh_ff;
      cross_in = cross_ff; ha_in = ha_ff; hb_in = hb_ff;
      case (cmd.op)
         bvf_pkg::OP_INIT: begin
            acc_in = bvf_pkg::ACC_INIT;
            a_in   = key_ff[63:0] ^ (bvf_pkg::SECRET[0] + seed);
            b_in   = key_ff[127:64] ^ (bvf_pkg::SECRET[1] - seed);
         end
         bvf_pkg::OP_MLL:   ll_in = mul_p;
         bvf_pkg::OP_MHL:   hl_in = mul_p;
         bvf_pkg::OP_MLH:   lh_in = mul_p;
         bvf_pkg::OP_MHH:   hh_in = mul_p;
         bvf_pkg::OP_CROSS: cross_in = {32'd0, ll_ff[63:32]} + {32'd0, hl_ff[31:0]} + lh_ff;
         bvf_pkg::OP_FOLD:  acc_in = acc_ff + (lower ^ upper);
         bvf_pkg::OP_LOAD2: begin
            a_in = tail_lo ^ (bvf_pkg::SECRET[2] + seed);
            b_in = tail_hi ^ (bvf_pkg::SECRET[3] - seed);
         end
         bvf_pkg::OP_AVAL: begin
            a_in = aval;
            b_in = bvf_pkg::AVAL_MUL;
         end
         bvf_pkg::OP_FINISH: begin
            if (cmd.seed_sel) hb_in = fin_lo ^ (fin_lo >> 32);
            else              ha_in = fin_lo ^ (fin_lo >> 32);
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      a_ff <= a_in; b_ff <= b_in; acc_ff <= acc_in;
      ll_ff <= ll_in; hl_ff <= hl_in; lh_ff <= lh_in; hh_ff <= hh_in;
      cross_ff <= cross_in; ha_ff <= ha_in; hb_ff <= hb_in;
      pos_ff <= pos_in;
      if (cmd.key_load) begin
         key_ff    <= {key_word_3, key_word_2, key_word_1, key_word_0};
         adding_ff <= operation;
      end
   end

   // probe i sits at ha + i*hb, kept modulo the filter size
   assign probe_addr = cmd.probe_first ? ha_ff[AW-1:0] : pos_ff;
   assign pos_in     = cmd.probe_en ? (probe_addr + hb_ff[AW-1:0]) : pos_ff;

   assign mem_we    = cmd.clear_en || (cmd.probe_en && adding_ff);
   assign mem_waddr = cmd.clear_en ? clr_addr_ff : probe_addr;
   assign mem_wdata = !cmd.clear_en;

   bvf_ram #(.WIDTH(1), .DEPTH(bvf_pkg::FILTER_BITS)) u_filter (
      .clock    (clock),
      .we       (mem_we),
      .waddr    (mem_waddr),
      .wdata    (mem_wdata),
      .raddr    (probe_addr),
      .rdata_ff (mem_rdata)
   );

   assign status.clear_last = cmd.clear_en && (clr_addr_ff == {AW{1'b1}});
   assign status.rsp_free   = !rsp_valid_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_addr_ff  <= '0;
         rd_pend_ff   <= 1'b0;
         all_set_ff   <= 1'b1;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.clear_en) clr_addr_ff <= clr_addr_ff + 1'b1;
         rd_pend_ff <= cmd.probe_en && !adding_ff;
         if (cmd.key_load) begin
            all_set_ff <= 1'b1;
         end else if (rd_pend_ff) begin
            all_set_ff <= all_set_ff & mem_rdata;
         end
         if (cmd.item_end && adding_ff && (count_ff != {bvf_pkg::COUNT_W{1'b1}})) begin
            count_ff <= count_ff + 1'b1;
         end
         if (cmd.rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rsp_load) begin
         rsp_visited_ff <= !adding_ff && (count_ff != '0) && all_set_ff;
         rsp_count_ff   <= count_ff;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_is_visited    = rsp_visited_ff;
   assign rsp_entries_added = rsp_count_ff;

   `BVF_ASSERT(a_count_step, clock, reset, (count_ff != $past(count_ff)) |-> (count_ff == bvf_pkg::COUNT_W'($past(count_ff) + 1'b1)), "add counter moved by other than one")
   `BVF_ASSERT(a_add_not_visited, clock, reset, (cmd.rsp_load && adding_ff) |=> !rsp_visited_ff, "add reported visited")
   `BVF_ASSERT(a_visited_nonzero, clock, reset, (rsp_valid_ff && rsp_visited_ff) |-> (rsp_count_ff != '0), "visited with empty counter")
   `BVF_ASSERT(a_no_probe_clear, clock, reset, cmd.clear_en |-> !cmd.probe_en && !cmd.key_load, "item work during clearing pass")

endmodule

`default_nettype wire

// ===== hdl/visited_bloom_filter.sv =====
// ----------------------------------------------------------------------------
// visited_bloom_filter
// bloom filter of seen keys, double hashing over seeded xxh3-64
// ----------------------------------------------------------------------------
// usage:
//  - req_chan carries one transaction per key: operation (1 = add, 0 = check)
//    and the 32-byte key as four little-endian 64-bit words
//  - rsp_chan returns exactly one transaction per request: is_visited (always
//    0 for an add) and entries_added, the saturating add count after the item
//  - one item at a time: accept, hash (two seeds, 19 steps each on
//    one shared 32x32 multiplier), 3 probes on the filter ram port,
//    a drain state, a response hand-off; a new request is taken only
//    after the previous item is done, while the response side keeps up
//  - the response sits in an output register; the next request is accepted
//    while it waits, and that item's result holds until the slot frees
//  - reset (synchronous) clears the counter and starts a clearing pass
//    over all 2048 bits of the filter ram, one bit per cycle; req_chan.ready
//    stays low until it ends
// ----------------------------------------------------------------------------
`default_nettype none

module visited_bloom_filter (
   input  logic      clock,
   input  logic      reset,
   bvf_req_if.sink   req_chan,
   bvf_rsp_if.source rsp_chan
);

   bvf_pkg::cmd_type    cmd;
   bvf_pkg::status_type status;

   bvf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .status    (status),
      .cmd       (cmd)
   );

   bvf_datapath u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .operation         (req_chan.operation),
      .key_word_0        (req_chan.key_word_0),
      .key_word_1        (req_chan.key_word_1),
      .key_word_2        (req_chan.key_word_2),
      .key_word_3        (req_chan.key_word_3),
      .rsp_ready         (rsp_chan.ready),
      .rsp_valid         (rsp_chan.valid),
      .rsp_is_visited    (rsp_chan.is_visited),
      .rsp_entries_added (rsp_chan.entries_added)
   );

endmodule

`default_nettype wire
